>>> sv/bmp2rgba_pkg.sv
// Shared types, register codes and color expansion tables for the BMP to RGBA8888 converter.
// Used by bmp2rgba_assemble, bmp2rgba_convert and bmp_pixel_stream_to_rgba8888.
package bmp2rgba_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int POS_W      = 12;
    localparam int OUT_DATA_W = 32 + 2 * POS_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    // pixel format codes; the unused code behaves as 32 bpp
    localparam logic [1:0] FMT_RGB565   = 2'd0;
    localparam logic [1:0] FMT_RGB888   = 2'd1;
    localparam logic [1:0] FMT_RGBA8888 = 2'd2;

    typedef struct packed {
        logic [1:0]            fmt;
        logic [CFG_DATA_W-1:0] width;
        logic [CFG_DATA_W-1:0] height;
    } t_cfg;

    typedef struct packed {
        logic             emit;
        logic             last;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [31:0]      pixel;
    } t_asm_result;

    typedef logic [31:0][7:0] t_e5_tab;
    typedef logic [63:0][7:0] t_e6_tab;

    function automatic t_e5_tab f_e5_tab();
        t_e5_tab tab;
        for (int i = 0; i < 32; i++) begin
            tab[i] = 8'((i * 255) / 31);
        end
        return tab;
    endfunction

    function automatic t_e6_tab f_e6_tab();
        t_e6_tab tab;
        for (int i = 0; i < 64; i++) begin
            tab[i] = 8'((i * 255) / 63);
        end
        return tab;
    endfunction

    localparam t_e5_tab E5_TAB = f_e5_tab();
    localparam t_e6_tab E6_TAB = f_e6_tab();

endpackage

>>> sv/bmp_pixel_stream_to_rgba8888.sv
// Accepts one BMP pixel-data byte per cycle and emits one RGBA8888 word per completed pixel,
// tagged with its column and top-down row. A byte is taken every cycle when the output side
// keeps up: each byte passes an input register, one pass of assembly and conversion logic, and
// a result register. The input stalls only when the result register is full, the downstream
// side holds off, and the byte waiting in the input register would complete a pixel. A write to
// any known register starts a new frame; bytes after the last pixel of the image are dropped
// until then. Rows arrive bottom-up, so the first row read reports row height-1 and the last
// pixel carries tlast.
// Depends on bmp2rgba_pkg, bmp2rgba_assemble and bmp2rgba_convert.
module bmp_pixel_stream_to_rgba8888 #(
    parameter int MAX_WIDTH  = bmp2rgba_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmp2rgba_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bmp2rgba_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bmp2rgba_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [7:0] data_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] pixel_word, [43:32] column, [55:44] row
    output logic [bmp2rgba_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                                m_axis_tlast    // last_pixel
);
    import bmp2rgba_pkg::*;

    t_cfg r_cfg;
    logic cfg_clear;

    logic       r_in_valid;
    logic [7:0] r_in_byte;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_last;

    t_asm_result asm_res;
    logic [31:0] n_word;
    logic        out_free;
    logic        consume;
    logic        emit;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fmt    <= FMT_RGBA8888;
            r_cfg.width  <= CFG_DATA_W'(1);
            r_cfg.height <= CFG_DATA_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PIXEL_FORMAT: r_cfg.fmt    <= i_cfg_data[1:0];
                CFG_IMAGE_WIDTH:  r_cfg.width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_cfg.height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg_clear = i_cfg_we && (i_cfg_idx == CFG_PIXEL_FORMAT ||
                                 i_cfg_idx == CFG_IMAGE_WIDTH  ||
                                 i_cfg_idx == CFG_IMAGE_HEIGHT);
    end

    // a held byte leaves the input register unless it completes a pixel and the
    // result register cannot take it this cycle
    always_comb begin
        emit          = r_in_valid && asm_res.emit;
        out_free      = !r_out_valid || m_axis_tready;
        consume       = r_in_valid && (out_free || !asm_res.emit);
        s_axis_tready = !r_in_valid || consume;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    bmp2rgba_assemble #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_assemble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_clear (cfg_clear),
        .i_fire  (consume),
        .i_byte  (r_in_byte),
        .o_res   (asm_res)
    );

    bmp2rgba_convert u_convert (
        .i_fmt   (r_cfg.fmt),
        .i_pixel (asm_res.pixel),
        .o_word  (n_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && emit) begin
            r_out_data <= {asm_res.row, asm_res.col, n_word};
            r_out_last <= asm_res.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    a_last_is_top_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[OUT_DATA_W-1 -: POS_W] == '0))
        else $error("last pixel not on the top row");

    a_pixel_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && emit) |=> m_axis_tvalid)
        else $error("completed pixel did not reach the result register");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !(consume && emit))
        else $error("result register overwritten while stalled");

endmodule

>>> sv/bmp2rgba_assemble.sv
// Byte assembly, row padding skip and column/row tracking for the BMP converter.
// Depends on bmp2rgba_pkg for the config and result structs and format codes.
module bmp2rgba_assemble #(
    parameter int MAX_WIDTH  = bmp2rgba_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmp2rgba_pkg::DEF_MAX_HEIGHT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bmp2rgba_pkg::t_cfg        i_cfg,
    input  logic                      i_clear,
    input  logic                      i_fire,
    input  logic [7:0]                i_byte,
    output bmp2rgba_pkg::t_asm_result o_res
);
    import bmp2rgba_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    logic [23:0]   r_partial;
    logic [1:0]    r_phase;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_rows;
    logic [1:0]    r_pad;
    logic          r_done;

    logic [CW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic [2:0]    bpp;
    logic          last_byte;
    logic [31:0]   full;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_rows;
    logic          row_end;
    logic [3:0]    row_bytes_lo;
    logic [1:0]    n_pad;
    logic [RW-1:0] dest_row;

    always_comb begin
        if (i_cfg.width == '0) begin
            w_eff = CW'(1);
        end else if (32'(i_cfg.width) > 32'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(i_cfg.width);
        end
        if (i_cfg.height == '0) begin
            h_eff = RW'(1);
        end else if (32'(i_cfg.height) > 32'(MAX_HEIGHT)) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(i_cfg.height);
        end

        case (i_cfg.fmt)
            FMT_RGB565: bpp = 3'd2;
            FMT_RGB888: bpp = 3'd3;
            default:    bpp = 3'd4;
        endcase

        last_byte = (3'(r_phase) + 3'd1) >= bpp;
        full      = {8'h00, r_partial} | (32'(i_byte) << {r_phase, 3'b000});

        n_col   = r_col + CW'(1);
        n_rows  = r_rows + RW'(1);
        row_end = n_col >= w_eff;

        // padding rounds row bytes up to a multiple of four
        row_bytes_lo = 4'(2'(w_eff)) * 4'(bpp);
        n_pad        = 2'(4'd0 - row_bytes_lo);

        dest_row = h_eff - RW'(1) - r_rows;

        o_res.emit  = !r_done && (r_pad == 2'd0) && last_byte;
        o_res.last  = (r_rows == h_eff - RW'(1)) && (r_col == w_eff - CW'(1));
        o_res.row   = POS_W'(32'(dest_row));
        o_res.col   = POS_W'(32'(r_col));
        o_res.pixel = full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_partial <= '0;
            r_phase   <= '0;
            r_col     <= '0;
            r_rows    <= '0;
            r_pad     <= '0;
            r_done    <= 1'b0;
        end else if (i_fire && !r_done) begin
            if (r_pad != 2'd0) begin
                r_pad <= r_pad - 2'd1;
            end else if (!last_byte) begin
                r_partial <= r_partial | 24'(32'(i_byte) << {r_phase, 3'b000});
                r_phase   <= r_phase + 2'd1;
            end else begin
                r_partial <= '0;
                r_phase   <= '0;
                if (row_end) begin
                    r_col  <= '0;
                    r_rows <= n_rows;
                    r_pad  <= n_pad;
                    r_done <= n_rows >= h_eff;
                end else begin
                    r_col <= n_col;
                end
            end
        end
    end

    a_no_emit_after_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !o_res.emit)
        else $error("pixel emitted after the image completed");

    a_no_emit_in_padding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pad != 2'd0) |-> !o_res.emit)
        else $error("pixel emitted while skipping row padding");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        3'(r_phase) < bpp)
        else $error("byte phase ran past the pixel size");

endmodule

>>> sv/bmp2rgba_convert.sv
// Pixel format conversion from an assembled little-endian BMP pixel to an RGBA8888 word.
// Depends on bmp2rgba_pkg for format codes and the 5/6-bit expansion tables.
module bmp2rgba_convert (
    input  logic [1:0]  i_fmt,
    input  logic [31:0] i_pixel,
    output logic [31:0] o_word
);
    import bmp2rgba_pkg::*;

    always_comb begin
        case (i_fmt)
            FMT_RGB565: begin
                o_word = {8'hFF, E5_TAB[i_pixel[4:0]], E6_TAB[i_pixel[10:5]],
                          E5_TAB[i_pixel[15:11]]};
            end
            FMT_RGB888: begin
                o_word = {8'hFF, i_pixel[7:0], i_pixel[15:8], i_pixel[23:16]};
            end
            default: begin
                o_word = {i_pixel[7:0], i_pixel[15:8], i_pixel[23:16], i_pixel[31:24]};
            end
        endcase
    end

endmodule
